/* rtl/core/button_hold_mode_controller_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the button hold mode controller.
// ----------------------------------------------------------------------------
`ifndef BUTTON_HOLD_MODE_CONTROLLER_ASSERT_SVH
`define BUTTON_HOLD_MODE_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHMC_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("button hold mode controller: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BHMC_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("button hold mode controller: assertion failed");

`endif

/* rtl/core/bhmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhmc_pkg
// Types and codes shared by the button hold mode controller modules.
// ----------------------------------------------------------------------------
package bhmc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE_DAY     = 3'd0,
    MODE_IDLE_NIGHT   = 3'd1,
    MODE_REMINDER     = 3'd2,
    MODE_NOT_YET      = 3'd3,
    MODE_ACTIVATION   = 3'd4,
    MODE_LISTENING    = 3'd5,
    MODE_DEACTIVATION = 3'd6
  } mode_t;

  localparam logic [1:0] REQ_BOOT    = 2'd0;
  localparam logic [1:0] REQ_UPDATE  = 2'd1;
  localparam logic [1:0] REQ_BACKEND = 2'd2;

  localparam logic [2:0] CFG_CLEAR_HOLD     = 3'd0;
  localparam logic [2:0] CFG_REMINDER_HOLD  = 3'd1;
  localparam logic [2:0] CFG_NOT_YET        = 3'd2;
  localparam logic [2:0] CFG_ACTIVATION     = 3'd3;
  localparam logic [2:0] CFG_LISTENING_HOLD = 3'd4;
  localparam logic [2:0] CFG_DEACTIVATION   = 3'd5;
  localparam logic [2:0] CFG_NIGHT_START    = 3'd6;
  localparam logic [2:0] CFG_NIGHT_END      = 3'd7;

  typedef struct packed {
    logic [15:0] clear_hold_ms;
    logic [15:0] reminder_hold_ms;
    logic [15:0] not_yet_ms;
    logic [15:0] activation_ms;
    logic [15:0] listening_hold_ms;
    logic [15:0] deactivation_ms;
    logic [4:0]  night_start_hour;
    logic [4:0]  night_end_hour;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic        button;
    logic        time_valid;
    logic [4:0]  hour;
    logic [39:0] now_epoch;
    logic        has_last_yap;
    logic [39:0] last_yap_epoch;
    logic [39:0] period_start_epoch;
    logic [2:0]  backend_mode;
  } item_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] mode_entered_ms;
    logic [31:0] press_started_ms;
    logic        button_before;
    logic        released_since_activation;
  } state_t;

  typedef struct packed {
    mode_t mode;
    logic  changed;
    logic  session_completed;
    logic  clear_requested;
  } result_t;

endpackage

/* rtl/core/button_hold_mode_controller.sv */
// A request is held in the input register, then its result is registered.
// Throughput: one request per cycle; the input register and result register
// run as a two-stage pipeline and stall only when the result is not taken.
// Reset: synchronous rst returns the mode to idle day, clears button history
// and loads the default thresholds; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_hold_mode_controller
// Seven-mode controller driven by one push button, time-of-day inputs and backend requests.
// ----------------------------------------------------------------------------
module button_hold_mode_controller
  import bhmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] now_ms,
  input  logic        button,
  input  logic        time_valid,
  input  logic [4:0]  hour,
  input  logic [39:0] now_epoch,
  input  logic        has_last_yap,
  input  logic [39:0] last_yap_epoch,
  input  logic [39:0] period_start_epoch,
  input  logic [2:0]  backend_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  mode,
  output logic        changed,
  output logic        session_completed,
  output logic        clear_requested
);

  `include "button_hold_mode_controller_assert.svh"

  cfg_t    cfg;
  item_t   in_item;
  item_t   inq;
  logic    inq_valid;
  logic    fire;
  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t res_q;

  bhmc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_item.req_type           = req_type;
  assign in_item.now_ms             = now_ms;
  assign in_item.button             = button;
  assign in_item.time_valid         = time_valid;
  assign in_item.hour               = hour;
  assign in_item.now_epoch          = now_epoch;
  assign in_item.has_last_yap       = has_last_yap;
  assign in_item.last_yap_epoch     = last_yap_epoch;
  assign in_item.period_start_epoch = period_start_epoch;
  assign in_item.backend_mode       = backend_mode;

  assign fire     = inq_valid && (!out_valid || out_ready);
  assign in_ready = !inq_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq <= in_item;
    end
  end

  bhmc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (inq),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode                      <= MODE_IDLE_DAY;
      st.mode_entered_ms           <= 32'd0;
      st.press_started_ms          <= 32'd0;
      st.button_before             <= 1'b0;
      st.released_since_activation <= 1'b0;
      out_valid                    <= 1'b0;
    end else begin
      if (fire) begin
        st <= st_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res_next;
    end
  end

  assign mode              = res_q.mode;
  assign changed           = res_q.changed;
  assign session_completed = res_q.session_completed;
  assign clear_requested   = res_q.clear_requested;

  `BHMC_ASSERT_IMP(a_changed_matches_mode, clk, rst, fire, res_next.changed == (st_next.mode != st.mode))
  `BHMC_ASSERT_IMP(a_session_only_from_listening, clk, rst, fire && res_next.session_completed, (st.mode == MODE_LISTENING) && (st_next.mode == MODE_DEACTIVATION))
  `BHMC_ASSERT_IMP(a_ready_when_empty, clk, rst, !inq_valid, in_ready)
  `BHMC_ASSERT_NXT(a_result_after_fire, clk, rst, fire, out_valid)

endmodule

/* rtl/core/bhmc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhmc_cfg_regs
// Threshold and night-hour registers written through the configuration port.
// ----------------------------------------------------------------------------
module bhmc_cfg_regs
  import bhmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clear_hold_ms     <= 16'd5000;
      cfg.reminder_hold_ms  <= 16'd1000;
      cfg.not_yet_ms        <= 16'd2000;
      cfg.activation_ms     <= 16'd2000;
      cfg.listening_hold_ms <= 16'd2000;
      cfg.deactivation_ms   <= 16'd3000;
      cfg.night_start_hour  <= 5'd22;
      cfg.night_end_hour    <= 5'd6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLEAR_HOLD:     cfg.clear_hold_ms     <= cfg_data;
        CFG_REMINDER_HOLD:  cfg.reminder_hold_ms  <= cfg_data;
        CFG_NOT_YET:        cfg.not_yet_ms        <= cfg_data;
        CFG_ACTIVATION:     cfg.activation_ms     <= cfg_data;
        CFG_LISTENING_HOLD: cfg.listening_hold_ms <= cfg_data;
        CFG_DEACTIVATION:   cfg.deactivation_ms   <= cfg_data;
        CFG_NIGHT_START:    cfg.night_start_hour  <= cfg_data[4:0];
        CFG_NIGHT_END:      cfg.night_end_hour    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/bhmc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhmc_step
// Next-state and result logic for one request against the current state.
// ----------------------------------------------------------------------------
module bhmc_step
  import bhmc_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_next,
  output result_t res
);

  logic        pressed;
  logic [31:0] press_start_n;
  logic        released_n;
  logic [31:0] held;
  logic [31:0] dwell;
  logic        night;
  logic        recorded;
  mode_t       resting;
  mode_t       tgt;
  logic        go;
  logic        changed;
  logic        sess;
  logic        clr;

  assign pressed       = item.button;
  assign press_start_n = (pressed && !st.button_before) ? item.now_ms : st.press_started_ms;
  assign released_n    = pressed ? st.released_since_activation : 1'b1;
  assign held          = item.now_ms - press_start_n;
  assign dwell         = item.now_ms - st.mode_entered_ms;

  assign night = item.time_valid &&
                 ((item.hour >= cfg.night_start_hour) || (item.hour < cfg.night_end_hour));

  assign recorded = item.has_last_yap && (item.period_start_epoch != 40'd0) &&
                    (item.last_yap_epoch >= item.period_start_epoch) &&
                    (item.last_yap_epoch <= item.now_epoch);

  always_comb begin
    if (!item.time_valid) begin
      resting = MODE_IDLE_DAY;
    end else if (!recorded) begin
      resting = MODE_REMINDER;
    end else begin
      resting = night ? MODE_IDLE_NIGHT : MODE_IDLE_DAY;
    end
  end

  always_comb begin
    st_next = st;
    changed = 1'b0;
    sess    = 1'b0;
    clr     = 1'b0;
    go      = 1'b0;
    tgt     = st.mode;
    unique case (item.req_type)
      REQ_BOOT: begin
        st_next.mode            = resting;
        st_next.mode_entered_ms = item.now_ms;
        changed                 = (resting != st.mode);
      end
      REQ_UPDATE: begin
        st_next.press_started_ms          = press_start_n;
        st_next.released_since_activation = released_n;
        st_next.button_before             = pressed;
        unique case (st.mode)
          MODE_IDLE_DAY, MODE_IDLE_NIGHT: begin
            go = 1'b1;
            if (pressed && (held >= {16'd0, cfg.clear_hold_ms})) begin
              clr = 1'b1;
              tgt = MODE_ACTIVATION;
            end else if (!pressed && st.button_before) begin
              tgt = MODE_NOT_YET;
            end else begin
              tgt = resting;
            end
          end
          MODE_REMINDER: begin
            if (pressed && (held >= {16'd0, cfg.reminder_hold_ms})) begin
              go  = 1'b1;
              tgt = MODE_ACTIVATION;
            end
          end
          MODE_NOT_YET: begin
            if (dwell >= {16'd0, cfg.not_yet_ms}) begin
              go  = 1'b1;
              tgt = resting;
            end
          end
          MODE_ACTIVATION: begin
            if (dwell >= {16'd0, cfg.activation_ms}) begin
              go  = 1'b1;
              tgt = MODE_LISTENING;
            end
          end
          MODE_LISTENING: begin
            if (released_n && pressed && (held >= {16'd0, cfg.listening_hold_ms})) begin
              sess = 1'b1;
              go   = 1'b1;
              tgt  = MODE_DEACTIVATION;
            end
          end
          MODE_DEACTIVATION: begin
            if (dwell >= {16'd0, cfg.deactivation_ms}) begin
              go  = 1'b1;
              tgt = night ? MODE_IDLE_NIGHT : MODE_IDLE_DAY;
            end
          end
          default: ;
        endcase
      end
      REQ_BACKEND: begin
        if ((item.backend_mode <= 3'(MODE_REMINDER)) && (st.mode <= MODE_NOT_YET)) begin
          go  = 1'b1;
          tgt = mode_t'(item.backend_mode);
        end
      end
      default: ;
    endcase

    if (go && (tgt != st.mode)) begin
      st_next.mode            = tgt;
      st_next.mode_entered_ms = item.now_ms;
      changed                 = 1'b1;
      if ((tgt == MODE_ACTIVATION) || (tgt == MODE_LISTENING) ||
          (tgt == MODE_DEACTIVATION)) begin
        st_next.released_since_activation = 1'b0;
      end
    end
  end

  assign res.mode              = st_next.mode;
  assign res.changed           = changed;
  assign res.session_completed = sess;
  assign res.clear_requested   = clr;

endmodule
